// File: design/bar_pkg.sv
// Shared types, codes and constants of the bus address range registry.
`default_nettype none

package bar_pkg;

    localparam int unsigned DEF_MAX_RANGES = 64;
    localparam int unsigned DEF_NUM_SPACES = 3;

    localparam logic [31:0] LIM_A16 = 32'h0000_ffff;
    localparam logic [31:0] LIM_A24 = 32'h00ff_ffff;
    localparam logic [31:0] LIM_A32 = 32'hffff_ffff;

    localparam logic REQ_REGISTER   = 1'b0;
    localparam logic REQ_UNREGISTER = 1'b1;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_BAD_SPACE   = 4'd1,
        ST_OVER_LIMIT  = 4'd2,
        ST_ZERO_SIZE   = 4'd3,
        ST_OVERLAP     = 4'd4,
        ST_INTERNAL    = 4'd5,
        ST_NOT_FOUND   = 4'd6,
        ST_WRONG_OWNER = 4'd7,
        ST_FULL        = 4'd8
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_RF_RD,
        S_RF_CHK,
        S_RO_RD,
        S_RO_CHK,
        S_R_FIX,
        S_R_SPLIT_INS,
        S_RP_RD,
        S_RP_CHK,
        S_R_OWN_SH,
        S_R_OWN_INS,
        S_UO_RD,
        S_UO_CHK,
        S_UF_RD,
        S_UF_CHK,
        S_U_FIX,
        S_U_FREE,
        S_U_INS,
        S_SH_RD,
        S_SH_WR,
        S_RESP
    } seq_state_t;

    function automatic logic [31:0] space_limit(input logic [1:0] s);
        logic [31:0] lim;
        case (s)
            2'd0:    lim = LIM_A16;
            2'd1:    lim = LIM_A24;
            default: lim = LIM_A32;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

// File: design/bar_ram.sv
// Simple dual-port table memory with a registered read.
`default_nettype none

module bar_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned AW    = 8
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/bus_address_range_registry.sv
// Top level of the bus address range registry: sequencer, counts and tables.
//
//  Channel | Direction | Ports                                              | Beat
//  s_      | in        | s_req_type s_addr_space s_base_addr s_range_size    | one request
//          |           | s_owner_id                                         |
//  m_      | out       | m_status m_conflict_owner                          | one result
//
// Each request walks its range tables entry by entry, in scans and in shifts, paced by
// the single read port of each range table.
// Only one request is in flight; s_ready is high solely while the sequencer is idle.
// Reset leaves one free range covering each whole space and no owned ranges.
// A result waits in its register until m_ready is high; no new request is taken meanwhile.
`default_nettype none

module bus_address_range_registry
    import bar_pkg::*;
#(
    parameter int unsigned MAX_RANGES = DEF_MAX_RANGES,
    parameter int unsigned NUM_SPACES = DEF_NUM_SPACES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [1:0]  s_addr_space,
    input  wire logic [31:0] s_base_addr,
    input  wire logic [31:0] s_range_size,
    input  wire logic [7:0]  s_owner_id,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_status,
    output logic [7:0]       m_conflict_owner
);

    localparam int unsigned IW = $clog2(MAX_RANGES);
    localparam int unsigned CW = $clog2(MAX_RANGES + 1);
    localparam int unsigned SW = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1;
    localparam int unsigned AW = SW + IW;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RANGES);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    seq_state_t state_reg, state_next;
    seq_state_t ret_reg, ret_next;

    logic [CW-1:0] fcnt_reg [NUM_SPACES];
    logic [CW-1:0] fcnt_next [NUM_SPACES];
    logic [CW-1:0] ocnt_reg [NUM_SPACES];
    logic [CW-1:0] ocnt_next [NUM_SPACES];
    logic [NUM_SPACES-1:0] f0init_reg, f0init_next;

    logic        req_reg, req_next;
    logic [1:0]  space_reg, space_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] size_reg, size_next;
    logic [32:0] last_reg, last_next;
    logic [7:0]  owner_reg, owner_next;
    status_t     status_reg, status_next;
    logic [7:0]  conflict_reg, conflict_next;

    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] hit_reg, hit_next;
    logic [CW-1:0] sh_i_reg, sh_i_next;
    logic [CW-1:0] sh_stop_reg, sh_stop_next;
    logic          sh_up_reg, sh_up_next;
    logic          sh_own_reg, sh_own_next;
    logic [31:0]   seg_first_reg, seg_first_next;
    logic [31:0]   seg_last_reg, seg_last_next;
    logic [31:0]   prev_first_reg, prev_first_next;
    logic [31:0]   prev_last_reg, prev_last_next;
    logic [31:0]   nxt_last_reg, nxt_last_next;
    logic [31:0]   nxt_first_reg, nxt_first_next;
    logic          ovr_reg, ovr_next;

    logic          f_we, f_re, o_we, o_re;
    logic [CW-1:0] f_widx, f_ridx, o_widx, o_ridx;
    logic [63:0]   f_wdata, f_rdata_raw, f_rdata;
    logic [71:0]   o_wdata, o_rdata;

    logic [SW-1:0] sp_w;
    logic [CW-1:0] fc, oc;
    logic [31:0]   lim, rf, rl, ro_f, ro_l, last_p1, base_m1;
    logic [7:0]    ro_o;
    logic          bad_space, rf_above, rf_cover, ro_above, ro_hit;
    logic          hf, hl, fc_full, oc_full, mb, ma, sh_go;
    logic [CW-1:0] sh_src;

    assign sp_w      = SW'(space_reg);
    assign fc        = fcnt_reg[sp_w];
    assign oc        = ocnt_reg[sp_w];
    assign lim       = space_limit(space_reg);
    assign bad_space = 32'(space_reg) >= NUM_SPACES;
    assign f_rdata   = ovr_reg ? {32'd0, lim} : f_rdata_raw;
    assign rf        = f_rdata[63:32];
    assign rl        = f_rdata[31:0];
    assign ro_f      = o_rdata[71:40];
    assign ro_l      = o_rdata[39:8];
    assign ro_o      = o_rdata[7:0];
    assign last_p1   = last_reg[31:0] + 32'd1;
    assign base_m1   = base_reg - 32'd1;
    assign rf_above  = {1'b0, rf} > last_reg;
    assign rf_cover  = (rf <= base_reg) && ({1'b0, rl} >= last_reg);
    assign ro_above  = {1'b0, ro_f} > last_reg;
    assign ro_hit    = ro_l >= base_reg;
    assign hf        = seg_first_reg == base_reg;
    assign hl        = {1'b0, seg_last_reg} == last_reg;
    assign fc_full   = fc >= CNT_MAX;
    assign oc_full   = oc >= CNT_MAX;
    assign mb        = (idx_reg != '0) &&
                       (({1'b0, prev_last_reg} + 33'd1) == {1'b0, seg_first_reg});
    assign ma        = (idx_reg < fc) &&
                       (({1'b0, seg_last_reg} + 33'd1) == {1'b0, nxt_first_reg});
    assign sh_go     = sh_up_reg ? (sh_i_reg > sh_stop_reg)
                                 : (({1'b0, sh_i_reg} + 1'b1) < {1'b0, sh_stop_reg});
    assign sh_src    = sh_up_reg ? (sh_i_reg - CNT_ONE) : (sh_i_reg + CNT_ONE);

    bar_ram #(.WIDTH(64), .AW(AW)) u_free_ram (
        .aclk  (aclk),
        .we    (f_we),
        .waddr ({sp_w, f_widx[IW-1:0]}),
        .wdata (f_wdata),
        .re    (f_re),
        .raddr ({sp_w, f_ridx[IW-1:0]}),
        .rdata (f_rdata_raw)
    );

    bar_ram #(.WIDTH(72), .AW(AW)) u_owned_ram (
        .aclk  (aclk),
        .we    (o_we),
        .waddr ({sp_w, o_widx[IW-1:0]}),
        .wdata (o_wdata),
        .re    (o_re),
        .raddr ({sp_w, o_ridx[IW-1:0]}),
        .rdata (o_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            f0init_reg <= '1;
            ovr_reg    <= 1'b0;
            for (int s = 0; s < NUM_SPACES; s++) begin
                fcnt_reg[s] <= CNT_ONE;
                ocnt_reg[s] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            f0init_reg <= f0init_next;
            ovr_reg    <= ovr_next;
            for (int s = 0; s < NUM_SPACES; s++) begin
                fcnt_reg[s] <= fcnt_next[s];
                ocnt_reg[s] <= ocnt_next[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        space_reg      <= space_next;
        base_reg       <= base_next;
        size_reg       <= size_next;
        last_reg       <= last_next;
        owner_reg      <= owner_next;
        status_reg     <= status_next;
        conflict_reg   <= conflict_next;
        idx_reg        <= idx_next;
        hit_reg        <= hit_next;
        sh_i_reg       <= sh_i_next;
        sh_stop_reg    <= sh_stop_next;
        sh_up_reg      <= sh_up_next;
        sh_own_reg     <= sh_own_next;
        seg_first_reg  <= seg_first_next;
        seg_last_reg   <= seg_last_next;
        prev_first_reg <= prev_first_next;
        prev_last_reg  <= prev_last_next;
        nxt_first_reg  <= nxt_first_next;
        nxt_last_reg   <= nxt_last_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (bad_space) begin
                    state_next = S_RESP;
                end else if (req_reg == REQ_REGISTER) begin
                    if (size_reg > lim || size_reg == 32'd0) begin
                        state_next = S_RESP;
                    end else begin
                        state_next = S_RF_RD;
                    end
                end else if (base_reg > lim) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_UO_RD;
                end
            end
            S_RF_RD:  state_next = (idx_reg < fc) ? S_RF_CHK : S_RO_RD;
            S_RF_CHK: state_next = rf_above ? S_RO_RD : (rf_cover ? S_R_FIX : S_RF_RD);
            S_RO_RD:  state_next = (idx_reg < oc) ? S_RO_CHK : S_RESP;
            S_RO_CHK: state_next = (ro_above || ro_hit) ? S_RESP : S_RO_RD;
            S_R_FIX: begin
                if (oc_full || (!hf && !hl && fc_full)) begin
                    state_next = S_RESP;
                end else if (hf && hl) begin
                    state_next = S_SH_RD;
                end else if (hf || hl) begin
                    state_next = S_RP_RD;
                end else begin
                    state_next = S_SH_RD;
                end
            end
            S_R_SPLIT_INS: state_next = S_RP_RD;
            S_RP_RD:       state_next = (idx_reg < oc) ? S_RP_CHK : S_R_OWN_SH;
            S_RP_CHK:      state_next = ro_above ? S_R_OWN_SH : S_RP_RD;
            S_R_OWN_SH:    state_next = S_SH_RD;
            S_R_OWN_INS:   state_next = S_RESP;
            S_UO_RD:       state_next = (idx_reg < oc) ? S_UO_CHK : S_RESP;
            S_UO_CHK: begin
                if (ro_f == base_reg) begin
                    state_next = (ro_o != owner_reg) ? S_RESP : S_UF_RD;
                end else if (ro_f > base_reg) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_UO_RD;
                end
            end
            S_UF_RD:  state_next = (idx_reg < fc) ? S_UF_CHK : S_U_FIX;
            S_UF_CHK: state_next = (seg_last_reg < rf) ? S_U_FIX : S_UF_RD;
            S_U_FIX:  state_next = (!mb && !ma && fc_full) ? S_RESP : S_SH_RD;
            S_U_FREE: begin
                if ((mb && ma) || (!mb && !ma)) begin
                    state_next = S_SH_RD;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_U_INS: state_next = S_RESP;
            S_SH_RD: state_next = sh_go ? S_SH_WR : ret_reg;
            S_SH_WR: state_next = S_SH_RD;
            S_RESP: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        ret_next        = ret_reg;
        f0init_next     = f0init_reg;
        fcnt_next       = fcnt_reg;
        ocnt_next       = ocnt_reg;
        req_next        = req_reg;
        space_next      = space_reg;
        base_next       = base_reg;
        size_next       = size_reg;
        last_next       = last_reg;
        owner_next      = owner_reg;
        status_next     = status_reg;
        conflict_next   = conflict_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        sh_i_next       = sh_i_reg;
        sh_stop_next    = sh_stop_reg;
        sh_up_next      = sh_up_reg;
        sh_own_next     = sh_own_reg;
        seg_first_next  = seg_first_reg;
        seg_last_next   = seg_last_reg;
        prev_first_next = prev_first_reg;
        prev_last_next  = prev_last_reg;
        nxt_first_next  = nxt_first_reg;
        nxt_last_next   = nxt_last_reg;
        f_we            = 1'b0;
        f_widx          = idx_reg;
        f_wdata         = '0;
        f_re            = 1'b0;
        f_ridx          = idx_reg;
        o_we            = 1'b0;
        o_widx          = idx_reg;
        o_wdata         = '0;
        o_re            = 1'b0;
        o_ridx          = idx_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next      = s_req_type;
                    space_next    = s_addr_space;
                    base_next     = s_base_addr;
                    size_next     = s_range_size;
                    last_next     = {1'b0, s_base_addr} + {1'b0, s_range_size} - 33'd1;
                    owner_next    = s_owner_id;
                    status_next   = ST_OK;
                    conflict_next = '0;
                    idx_next      = '0;
                end
            end
            S_DECODE: begin
                if (bad_space) begin
                    status_next = ST_BAD_SPACE;
                end else if (req_reg == REQ_REGISTER) begin
                    if (size_reg > lim) begin
                        status_next = ST_OVER_LIMIT;
                    end else if (size_reg == 32'd0) begin
                        status_next = ST_ZERO_SIZE;
                    end
                end else if (base_reg > lim) begin
                    status_next = ST_OVER_LIMIT;
                end
            end
            S_RF_RD: begin
                if (idx_reg < fc) begin
                    f_re = 1'b1;
                end else begin
                    idx_next = '0;
                end
            end
            S_RF_CHK: begin
                if (rf_above) begin
                    idx_next = '0;
                end else if (rf_cover) begin
                    seg_first_next = rf;
                    seg_last_next  = rl;
                end else begin
                    idx_next = idx_reg + CNT_ONE;
                end
            end
            S_RO_RD: begin
                if (idx_reg < oc) begin
                    o_re = 1'b1;
                end else begin
                    status_next = ST_INTERNAL;
                end
            end
            S_RO_CHK: begin
                if (ro_above) begin
                    status_next = ST_INTERNAL;
                end else if (ro_hit) begin
                    status_next   = ST_OVERLAP;
                    conflict_next = ro_o;
                end else begin
                    idx_next = idx_reg + CNT_ONE;
                end
            end
            S_R_FIX: begin
                sh_own_next = 1'b0;
                if (oc_full || (!hf && !hl && fc_full)) begin
                    status_next = ST_FULL;
                end else if (hf && hl) begin
                    sh_i_next         = idx_reg;
                    sh_stop_next      = fc;
                    sh_up_next        = 1'b0;
                    ret_next          = S_RP_RD;
                    fcnt_next[sp_w]   = fc - CNT_ONE;
                    idx_next          = '0;
                end else if (hf) begin
                    f_we     = 1'b1;
                    f_wdata  = {last_p1, seg_last_reg};
                    idx_next = '0;
                end else if (hl) begin
                    f_we     = 1'b1;
                    f_wdata  = {seg_first_reg, base_m1};
                    idx_next = '0;
                end else begin
                    f_we         = 1'b1;
                    f_wdata      = {seg_first_reg, base_m1};
                    sh_i_next    = fc;
                    sh_stop_next = idx_reg + CNT_ONE;
                    sh_up_next   = 1'b1;
                    ret_next     = S_R_SPLIT_INS;
                    idx_next     = idx_reg + CNT_ONE;
                end
            end
            S_R_SPLIT_INS: begin
                f_we            = 1'b1;
                f_wdata         = {last_p1, seg_last_reg};
                fcnt_next[sp_w] = fc + CNT_ONE;
                idx_next        = '0;
            end
            S_RP_RD: begin
                if (idx_reg < oc) begin
                    o_re = 1'b1;
                end
            end
            S_RP_CHK: begin
                if (!ro_above) begin
                    idx_next = idx_reg + CNT_ONE;
                end
            end
            S_R_OWN_SH: begin
                sh_i_next    = oc;
                sh_stop_next = idx_reg;
                sh_up_next   = 1'b1;
                sh_own_next  = 1'b1;
                ret_next     = S_R_OWN_INS;
            end
            S_R_OWN_INS: begin
                o_we            = 1'b1;
                o_wdata         = {base_reg, last_reg[31:0], owner_reg};
                ocnt_next[sp_w] = oc + CNT_ONE;
            end
            S_UO_RD: begin
                if (idx_reg < oc) begin
                    o_re = 1'b1;
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            S_UO_CHK: begin
                if (ro_f == base_reg) begin
                    if (ro_o != owner_reg) begin
                        status_next = ST_WRONG_OWNER;
                    end else begin
                        seg_first_next = ro_f;
                        seg_last_next  = ro_l;
                        hit_next       = idx_reg;
                        idx_next       = '0;
                    end
                end else if (ro_f > base_reg) begin
                    status_next = ST_NOT_FOUND;
                end else begin
                    idx_next = idx_reg + CNT_ONE;
                end
            end
            S_UF_RD: begin
                if (idx_reg < fc) begin
                    f_re = 1'b1;
                end
            end
            S_UF_CHK: begin
                if (seg_last_reg < rf) begin
                    nxt_first_next = rf;
                    nxt_last_next  = rl;
                end else begin
                    prev_first_next = rf;
                    prev_last_next  = rl;
                    idx_next        = idx_reg + CNT_ONE;
                end
            end
            S_U_FIX: begin
                if (!mb && !ma && fc_full) begin
                    status_next = ST_FULL;
                end else begin
                    sh_i_next       = hit_reg;
                    sh_stop_next    = oc;
                    sh_up_next      = 1'b0;
                    sh_own_next     = 1'b1;
                    ret_next        = S_U_FREE;
                    ocnt_next[sp_w] = oc - CNT_ONE;
                end
            end
            S_U_FREE: begin
                sh_own_next = 1'b0;
                if (mb && ma) begin
                    f_we            = 1'b1;
                    f_widx          = idx_reg - CNT_ONE;
                    f_wdata         = {prev_first_reg, nxt_last_reg};
                    fcnt_next[sp_w] = fc - CNT_ONE;
                    sh_i_next       = idx_reg;
                    sh_stop_next    = fc;
                    sh_up_next      = 1'b0;
                    ret_next        = S_RESP;
                end else if (mb) begin
                    f_we    = 1'b1;
                    f_widx  = idx_reg - CNT_ONE;
                    f_wdata = {prev_first_reg, seg_last_reg};
                end else if (ma) begin
                    f_we    = 1'b1;
                    f_wdata = {seg_first_reg, nxt_last_reg};
                end else begin
                    sh_i_next    = fc;
                    sh_stop_next = idx_reg;
                    sh_up_next   = 1'b1;
                    ret_next     = S_U_INS;
                end
            end
            S_U_INS: begin
                f_we            = 1'b1;
                f_wdata         = {seg_first_reg, seg_last_reg};
                fcnt_next[sp_w] = fc + CNT_ONE;
            end
            S_SH_RD: begin
                if (sh_go) begin
                    f_re   = !sh_own_reg;
                    f_ridx = sh_src;
                    o_re   = sh_own_reg;
                    o_ridx = sh_src;
                end
            end
            S_SH_WR: begin
                f_we      = !sh_own_reg;
                f_widx    = sh_i_reg;
                f_wdata   = f_rdata;
                o_we      = sh_own_reg;
                o_widx    = sh_i_reg;
                o_wdata   = o_rdata;
                sh_i_next = sh_up_reg ? (sh_i_reg - CNT_ONE) : (sh_i_reg + CNT_ONE);
            end
            default: begin
            end
        endcase
        ovr_next = f_re ? ((f_ridx == '0) && f0init_reg[sp_w]) : ovr_reg;
        if (f_we && (f_widx == '0)) begin
            f0init_next[sp_w] = 1'b0;
        end
    end

    assign s_ready          = state_reg == S_IDLE;
    assign m_valid          = state_reg == S_RESP;
    assign m_status         = status_reg;
    assign m_conflict_owner = conflict_reg;

`ifndef SYNTH
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request and result sides active together");
    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> s_ready)
        else $error("sequencer did not return to idle after a result beat");
    a_conflict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OVERLAP)) |-> (m_conflict_owner == 8'd0))
        else $error("conflict owner set without an overlap status");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE && !bad_space) |-> (fc <= CNT_MAX && oc <= CNT_MAX))
        else $error("range count beyond table depth");
    a_single_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(f_we && o_we))
        else $error("both tables written in one cycle");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_bus_address_range_registry.sv
// Self-checking testbench of the bus address range registry with its own table predictor.
`default_nettype none

module tb_bus_address_range_registry
    import bar_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TBL_DEPTH = DEF_MAX_RANGES;
    localparam int unsigned SPACES    = DEF_NUM_SPACES;
    localparam int unsigned STALL_LIMIT = 20000;

    typedef struct packed {
        status_t    status;
        logic [7:0] owner;
    } outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = REQ_REGISTER;
    logic [1:0]  s_addr_space = 2'd0;
    logic [31:0] s_base_addr = 32'd0;
    logic [31:0] s_range_size = 32'd0;
    logic [7:0]  s_owner_id = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_status;
    logic [7:0]  m_conflict_owner;

    bus_address_range_registry u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_addr_space(s_addr_space), .s_base_addr(s_base_addr),
        .s_range_size(s_range_size), .s_owner_id(s_owner_id),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_conflict_owner(m_conflict_owner)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    logic [31:0] fr_lo [SPACES][TBL_DEPTH];
    logic [31:0] fr_hi [SPACES][TBL_DEPTH];
    int unsigned fr_n [SPACES];
    logic [31:0] own_lo [SPACES][TBL_DEPTH];
    logic [31:0] own_hi [SPACES][TBL_DEPTH];
    logic [7:0]  own_id [SPACES][TBL_DEPTH];
    int unsigned own_n [SPACES];

    outcome_t pending_outcomes [$];
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;
    bit rx_steady = 1'b0;
    bit tx_steady = 1'b0;

    function automatic logic [31:0] lim_of(input int s);
        return (s == 0) ? LIM_A16 : (s == 1) ? LIM_A24 : LIM_A32;
    endfunction

    task automatic table_reset();
        for (int s = 0; s < SPACES; s++) begin
            fr_lo[s][0] = 32'd0;
            fr_hi[s][0] = lim_of(s);
            fr_n[s] = 1;
            own_n[s] = 0;
        end
    endtask

    task automatic carve_range(input int s, input logic [31:0] b, input logic [31:0] sz,
                               input logic [7:0] id, output outcome_t o);
        logic [32:0] lo, hi;
        logic [31:0] ff, fl;
        int idx, pos;
        bit hit;
        lo = {1'b0, b};
        hi = lo + {1'b0, sz} - 33'd1;
        hit = 0;
        idx = 0;
        o = '{ST_OK, 8'd0};
        if (sz > lim_of(s)) begin
            o.status = ST_OVER_LIMIT;
            return;
        end
        if (sz == 0) begin
            o.status = ST_ZERO_SIZE;
            return;
        end
        for (int i = 0; i < fr_n[s]; i++) begin
            if ({1'b0, fr_lo[s][i]} > hi) break;
            if ({1'b0, fr_lo[s][i]} <= lo && {1'b0, fr_hi[s][i]} >= hi) begin
                idx = i;
                hit = 1;
                break;
            end
        end
        if (!hit) begin
            o.status = ST_INTERNAL;
            for (int i = 0; i < own_n[s]; i++) begin
                if ({1'b0, own_lo[s][i]} > hi) break;
                if ({1'b0, own_hi[s][i]} >= lo) begin
                    o.status = ST_OVERLAP;
                    o.owner = own_id[s][i];
                    break;
                end
            end
            return;
        end
        ff = fr_lo[s][idx];
        fl = fr_hi[s][idx];
        if (own_n[s] >= TBL_DEPTH ||
            ({1'b0, ff} != lo && {1'b0, fl} != hi && fr_n[s] >= TBL_DEPTH)) begin
            o.status = ST_FULL;
            return;
        end
        if ({1'b0, ff} == lo && {1'b0, fl} == hi) begin
            for (int i = idx; i + 1 < fr_n[s]; i++) begin
                fr_lo[s][i] = fr_lo[s][i+1];
                fr_hi[s][i] = fr_hi[s][i+1];
            end
            fr_n[s]--;
        end else if ({1'b0, ff} == lo) begin
            fr_lo[s][idx] = hi[31:0] + 32'd1;
        end else if ({1'b0, fl} == hi) begin
            fr_hi[s][idx] = b - 32'd1;
        end else begin
            fr_hi[s][idx] = b - 32'd1;
            for (int i = fr_n[s]; i > idx + 1; i--) begin
                fr_lo[s][i] = fr_lo[s][i-1];
                fr_hi[s][i] = fr_hi[s][i-1];
            end
            fr_lo[s][idx+1] = hi[31:0] + 32'd1;
            fr_hi[s][idx+1] = fl;
            fr_n[s]++;
        end
        pos = own_n[s];
        for (int i = 0; i < own_n[s]; i++) begin
            if (hi < {1'b0, own_lo[s][i]}) begin
                pos = i;
                break;
            end
        end
        for (int i = own_n[s]; i > pos; i--) begin
            own_lo[s][i] = own_lo[s][i-1];
            own_hi[s][i] = own_hi[s][i-1];
            own_id[s][i] = own_id[s][i-1];
        end
        own_lo[s][pos] = b;
        own_hi[s][pos] = hi[31:0];
        own_id[s][pos] = id;
        own_n[s]++;
    endtask

    task automatic release_range(input int s, input logic [31:0] b, input logic [7:0] id,
                                 output outcome_t o);
        int idx, pos;
        bit hit, join_lo, join_hi;
        logic [31:0] f, l;
        hit = 0;
        idx = 0;
        o = '{ST_OK, 8'd0};
        if (b > lim_of(s)) begin
            o.status = ST_OVER_LIMIT;
            return;
        end
        for (int i = 0; i < own_n[s]; i++) begin
            if (own_lo[s][i] == b) begin
                idx = i;
                hit = 1;
                break;
            end
            if (own_lo[s][i] > b) break;
        end
        if (!hit) begin
            o.status = ST_NOT_FOUND;
            return;
        end
        if (own_id[s][idx] != id) begin
            o.status = ST_WRONG_OWNER;
            return;
        end
        f = own_lo[s][idx];
        l = own_hi[s][idx];
        pos = fr_n[s];
        for (int i = 0; i < fr_n[s]; i++) begin
            if (l < fr_lo[s][i]) begin
                pos = i;
                break;
            end
        end
        join_lo = pos > 0 && ({1'b0, fr_hi[s][pos-1]} + 33'd1 == {1'b0, f});
        join_hi = pos < fr_n[s] && ({1'b0, l} + 33'd1 == {1'b0, fr_lo[s][pos]});
        if (!join_lo && !join_hi && fr_n[s] >= TBL_DEPTH) begin
            o.status = ST_FULL;
            return;
        end
        for (int i = idx; i + 1 < own_n[s]; i++) begin
            own_lo[s][i] = own_lo[s][i+1];
            own_hi[s][i] = own_hi[s][i+1];
            own_id[s][i] = own_id[s][i+1];
        end
        own_n[s]--;
        if (join_lo && join_hi) begin
            fr_hi[s][pos-1] = fr_hi[s][pos];
            for (int i = pos; i + 1 < fr_n[s]; i++) begin
                fr_lo[s][i] = fr_lo[s][i+1];
                fr_hi[s][i] = fr_hi[s][i+1];
            end
            fr_n[s]--;
        end else if (join_lo) begin
            fr_hi[s][pos-1] = l;
        end else if (join_hi) begin
            fr_lo[s][pos] = f;
        end else begin
            for (int i = fr_n[s]; i > pos; i--) begin
                fr_lo[s][i] = fr_lo[s][i-1];
                fr_hi[s][i] = fr_hi[s][i-1];
            end
            fr_lo[s][pos] = f;
            fr_hi[s][pos] = l;
            fr_n[s]++;
        end
    endtask

    task automatic send_request(input logic rt, input logic [1:0] sp, input logic [31:0] b,
                                input logic [31:0] sz, input logic [7:0] id);
        outcome_t o;
        @(negedge aclk);
        if (!tx_steady) begin
            while ($urandom_range(99) < 17) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= rt;
        s_addr_space <= sp;
        s_base_addr <= b;
        s_range_size <= sz;
        s_owner_id <= id;
        do @(posedge aclk); while (!s_ready);
        if (sp >= SPACES) o = '{ST_BAD_SPACE, 8'd0};
        else if (rt == REQ_REGISTER) carve_range(sp, b, sz, id, o);
        else release_range(sp, b, id, o);
        pending_outcomes.push_back(o);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_outcomes.size() != 0) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= rx_steady ? 1'b1 : ($urandom_range(99) >= 17);
    end

    always @(posedge aclk) begin
        outcome_t exp_o;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result status %0d owner %0d", $realtime,
                         m_status, m_conflict_owner);
                errors++;
            end else begin
                exp_o = pending_outcomes.pop_front();
                if (m_status != exp_o.status) begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             exp_o.status, m_status);
                    errors++;
                end
                if (m_conflict_owner != exp_o.owner) begin
                    $display("%0t: conflict owner expected %0d actual %0d", $realtime,
                             exp_o.owner, m_conflict_owner);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_corner_cases();
        send_request(REQ_REGISTER, 2'd3, 32'h0, 32'h10, 8'd1);
        send_request(REQ_UNREGISTER, 2'd3, 32'hffff_ffff, 32'h0, 8'hff);
        send_request(REQ_REGISTER, 2'd0, 32'h0, 32'h1_0000, 8'd1);
        send_request(REQ_REGISTER, 2'd1, 32'h0, 32'h0, 8'd1);
        send_request(REQ_REGISTER, 2'd0, 32'hfff0, 32'h20, 8'd2);
        send_request(REQ_REGISTER, 2'd0, 32'h100, 32'h100, 8'd3);
        send_request(REQ_REGISTER, 2'd0, 32'h180, 32'h10, 8'd4);
        send_request(REQ_REGISTER, 2'd0, 32'h1000, 32'h10, 8'd5);
        send_request(REQ_UNREGISTER, 2'd0, 32'h1_0000, 32'h0, 8'd3);
        send_request(REQ_UNREGISTER, 2'd0, 32'h104, 32'h0, 8'd3);
        send_request(REQ_UNREGISTER, 2'd0, 32'h100, 32'h0, 8'd9);
        send_request(REQ_UNREGISTER, 2'd0, 32'h100, 32'h0, 8'd3);
        send_request(REQ_UNREGISTER, 2'd0, 32'h1000, 32'h0, 8'd5);
        send_request(REQ_REGISTER, 2'd2, 32'h0, 32'hffff_ffff, 8'hff);
        send_request(REQ_REGISTER, 2'd2, 32'hffff_ffff, 32'h1, 8'h80);
        send_request(REQ_UNREGISTER, 2'd2, 32'h0, 32'h0, 8'hff);
        send_request(REQ_REGISTER, 2'd2, 32'hffff_ffff, 32'h1, 8'h80);
        send_request(REQ_REGISTER, 2'd1, 32'h00ff_ff00, 32'h00ff_ffff, 8'h7f);
        send_request(REQ_REGISTER, 2'd1, 32'h00ff_ff00, 32'h100, 8'h7f);
        send_request(REQ_UNREGISTER, 2'd2, 32'hffff_ffff, 32'h0, 8'h80);
        wait_drained();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < TBL_DEPTH + 2; i++)
            send_request(REQ_REGISTER, 2'd1, 32'h1000 + 32'(i) * 32'h20, 32'h10, 8'(i));
        for (int i = 0; i < TBL_DEPTH + 2; i += 2)
            send_request(REQ_UNREGISTER, 2'd1, 32'h1000 + 32'(i) * 32'h20, 32'h0, 8'(i));
        for (int i = 1; i < TBL_DEPTH + 2; i += 2)
            send_request(REQ_UNREGISTER, 2'd1, 32'h1000 + 32'(i) * 32'h20, 32'h0, 8'(i));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned count);
        logic [1:0] sp;
        logic [31:0] b, sz;
        int s, k;
        for (int n = 0; n < count; n++) begin
            tx_steady = (n >= count / 3 && n < count / 2);
            rx_steady = tx_steady;
            sp = ($urandom_range(99) < 5) ? 2'd3 : 2'($urandom_range(2));
            s = (sp == 2'd3) ? 0 : sp;
            k = $urandom_range(99);
            if (k < 45) begin
                b = (sp == 2'd2 && $urandom_range(3) == 0) ? $urandom
                    : 32'($urandom_range(255)) << 4;
                sz = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(64, 1));
                if ($urandom_range(29) == 0) sz = 32'h0;
                send_request(REQ_REGISTER, sp, b, sz, 8'($urandom));
            end else if (k < 85 && own_n[s] > 0) begin
                k = $urandom_range(own_n[s] - 1);
                send_request(REQ_UNREGISTER, sp, own_lo[s][k], $urandom,
                             ($urandom_range(9) == 0) ? 8'($urandom) : own_id[s][k]);
            end else begin
                send_request(REQ_UNREGISTER, sp, $urandom_range(1) ? $urandom
                             : 32'($urandom_range(4095)), $urandom, 8'($urandom));
            end
            if (n == count / 4) wait_drained();
        end
        tx_steady = 0;
        rx_steady = 0;
        wait_drained();
    endtask

    initial begin
        table_reset();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        test_corner_cases();
        test_table_full();
        test_random_traffic(500);
        repeat (50) @(negedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
